FILE: rtl/core/tc_pkg.sv
// ----------------------------------------------------------------------------
// tc_pkg: shared types and constants of the tetrahedron circumcenter block
// Holds the queue depth, the multiplier chunk width, the queue status word
// and the width rules for the words that pass from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package tc_pkg;

    // Entries of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Width of one unsigned operand slice in the multipliers
    localparam int CHUNK_W = 32;

    // Status of the queue as seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } tc_qstat_t;

    // Width of the system determinant for a given coordinate width
    function automatic int tc_det_w(input int w);
        return 3 * w + 6;
    endfunction

    // Width of one Cramer numerator for a given coordinate width
    function automatic int tc_num_w(input int w);
        return 4 * w + 9;
    endfunction

    // Width of one classified word: singular, three signs, |det|, three |num|
    function automatic int tc_item_w(input int w);
        return 4 + tc_det_w(w) + 3 * tc_num_w(w);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tc_in_if.sv
// ----------------------------------------------------------------------------
// tc_in_if: vertex channel
// Carries the twelve vertex coordinates of one tetrahedron with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tc_in_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] az;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by_coord;
    logic signed [W-1:0] bz;
    logic signed [W-1:0] cx_in;
    logic signed [W-1:0] cy_in;
    logic signed [W-1:0] cz_in;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] dz;

    modport source (
        output valid, ax, ay, az, bx, by_coord, bz, cx_in, cy_in, cz_in, dx, dy, dz,
        input  ready
    );

    modport sink (
        input  valid, ax, ay, az, bx, by_coord, bz, cx_in, cy_in, cz_in, dx, dy, dz,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/tc_out_if.sv
// ----------------------------------------------------------------------------
// tc_out_if: circumcenter channel
// Carries one circumcenter with its singular and saturated flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface tc_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] center_x;
    logic signed [W-1:0] center_y;
    logic signed [W-1:0] center_z;
    logic                singular;
    logic                saturated;

    modport source (
        output valid, center_x, center_y, center_z, singular, saturated,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, center_z, singular, saturated,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/tc_mul.sv
// ----------------------------------------------------------------------------
// tc_mul: two-stage signed multiplier
// Slices both operands into 32-bit parts, registers the partial products,
// then registers their shifted sum. Both stages advance on en.
// ----------------------------------------------------------------------------
`default_nettype none

module tc_mul
    import tc_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 33
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NA  = (WA + CHUNK_W - 3) / CHUNK_W;
    localparam int NB  = (WB + CHUNK_W - 3) / CHUNK_W;
    localparam int CW  = CHUNK_W + 3;
    localparam int WP  = WA + WB;
    localparam int WAX = WA + CHUNK_W;
    localparam int WBX = WB + CHUNK_W;

    logic signed [CW-1:0]   ca [NA];
    logic signed [CW-1:0]   cb [NB];
    logic signed [2*CW-1:0] pp_reg [NA][NB];
    logic signed [WP-1:0]   p_next;
    logic signed [WP-1:0]   p_reg;

    // Slice operands: lower parts unsigned, top part signed
    always_comb
    begin
        logic signed [WAX-1:0] ta;
        logic signed [WBX-1:0] tb;
        for (int i = 0; i < NA; i++)
        begin
            ta = WAX'(a) >>> (CHUNK_W * i);
            ca[i] = (i == NA - 1) ? CW'(ta) : CW'({1'b0, ta[CHUNK_W-1:0]});
        end
        for (int j = 0; j < NB; j++)
        begin
            tb = WBX'(b) >>> (CHUNK_W * j);
            cb[j] = (j == NB - 1) ? CW'(tb) : CW'({1'b0, tb[CHUNK_W-1:0]});
        end
    end

    // Register partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= ca[i] * cb[j];
                end
            end
        end
    end

    // Align and add partial products
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                p_next = p_next + (WP'(pp_reg[i][j]) <<< (CHUNK_W * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tc_front.sv
// ----------------------------------------------------------------------------
// tc_front: system setup and classification
// Accepts a tetrahedron, builds edge matrix, right-hand side and cofactors,
// forms the determinant and the three Cramer numerators, flags a singular
// system and pushes the word of magnitudes and signs into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tc_front
    import tc_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    tc_in_if.sink                   tet,
    input  tc_qstat_t               qstat,
    output logic                    push,
    output logic [tc_item_w(W)-1:0] item
);

    localparam int WM  = W + 1;
    localparam int WR  = 2 * W + 4;
    localparam int WC  = 2 * W + 3;
    localparam int WD  = tc_det_w(W);
    localparam int WN  = tc_num_w(W);
    localparam int NST = 8;

    logic               en;
    logic [NST-1:0]     vld_reg;
    logic signed [W-1:0] vtx [12];

    logic signed [WM-1:0]      m_reg [9];
    logic signed [WM-1:0]      s_reg [9];
    logic signed [WM-1:0]      mc_reg [3][3];
    logic signed [2*WM-1:0]    ms [9];
    logic signed [2*WM-1:0]    mna [9];
    logic signed [2*WM-1:0]    mnb [9];
    logic signed [WC-1:0]      cof_next [9];
    logic signed [WR-1:0]      rhs_reg [3];
    logic signed [WC-1:0]      cof_reg [9];
    logic signed [WR+WC-1:0]   rc [9];
    logic signed [WM+WC-1:0]   dc [3];
    logic signed [WN-1:0]      num_reg [3];
    logic signed [WD-1:0]      det_reg;
    logic                      sing_reg;
    logic [2:0]                neg_reg;
    logic [WD-1:0]             adet_reg;
    logic [WN-1:0]             anum_reg [3];

    // Stall the whole front only when its last word cannot enter the queue
    assign en        = !(vld_reg[NST-1] && qstat.full);
    assign tet.ready = en;
    assign push      = vld_reg[NST-1] && !qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], tet.valid};
        end
    end

    // Gather vertices: rows a, b, c, then d
    always_comb
    begin
        vtx[0]  = tet.ax;
        vtx[1]  = tet.ay;
        vtx[2]  = tet.az;
        vtx[3]  = tet.bx;
        vtx[4]  = tet.by_coord;
        vtx[5]  = tet.bz;
        vtx[6]  = tet.cx_in;
        vtx[7]  = tet.cy_in;
        vtx[8]  = tet.cz_in;
        vtx[9]  = tet.dx;
        vtx[10] = tet.dy;
        vtx[11] = tet.dz;
    end

    // Form edge differences and vertex sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    m_reg[r*3+k] <= WM'(vtx[9+k]) - WM'(vtx[r*3+k]);
                    s_reg[r*3+k] <= WM'(vtx[9+k]) + WM'(vtx[r*3+k]);
                end
            end
        end
    end

    // Carry the first matrix column alongside the multipliers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mc_reg[0][r] <= m_reg[r*3];
                mc_reg[1][r] <= mc_reg[0][r];
                mc_reg[2][r] <= mc_reg[1][r];
            end
        end
    end

    // Multiply edge by vertex sum, and form the 2x2 minor products
    for (genvar g = 0; g < 9; g++)
    begin : g_first
        localparam int R  = g / 3;
        localparam int K  = g % 3;
        localparam int R1 = (R == 0) ? 1 : 0;
        localparam int R2 = (R == 2) ? 1 : 2;
        localparam int K1 = (K == 0) ? 1 : 0;
        localparam int K2 = (K == 2) ? 1 : 2;

        tc_mul #(.WA(WM), .WB(WM)) u_ms (
            .clk (clk),
            .en  (en),
            .a   (m_reg[g]),
            .b   (s_reg[g]),
            .p   (ms[g])
        );

        tc_mul #(.WA(WM), .WB(WM)) u_mna (
            .clk (clk),
            .en  (en),
            .a   (m_reg[R1*3+K1]),
            .b   (m_reg[R2*3+K2]),
            .p   (mna[g])
        );

        tc_mul #(.WA(WM), .WB(WM)) u_mnb (
            .clk (clk),
            .en  (en),
            .a   (m_reg[R1*3+K2]),
            .b   (m_reg[R2*3+K1]),
            .p   (mnb[g])
        );
    end

    // Apply the checkerboard sign to each minor
    always_comb
    begin
        logic signed [WC-1:0] diff;
        for (int i = 0; i < 9; i++)
        begin
            diff = WC'(mna[i]) - WC'(mnb[i]);
            cof_next[i] = (((i / 3) + (i % 3)) % 2 == 1) ? -diff : diff;
        end
    end

    // Register right-hand side and cofactors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rhs_reg[r] <= WR'(ms[r*3]) + WR'(ms[r*3+1]) + WR'(ms[r*3+2]);
            end
            for (int i = 0; i < 9; i++)
            begin
                cof_reg[i] <= cof_next[i];
            end
        end
    end

    // Multiply cofactors by right-hand side and by the first column
    for (genvar g = 0; g < 9; g++)
    begin : g_rc
        tc_mul #(.WA(WR), .WB(WC)) u_rc (
            .clk (clk),
            .en  (en),
            .a   (rhs_reg[g/3]),
            .b   (cof_reg[g]),
            .p   (rc[g])
        );
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_dc
        tc_mul #(.WA(WM), .WB(WC)) u_dc (
            .clk (clk),
            .en  (en),
            .a   (mc_reg[2][r]),
            .b   (cof_reg[r*3]),
            .p   (dc[r])
        );
    end

    // Sum down the columns into numerators and determinant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= WN'(rc[k]) + WN'(rc[3+k]) + WN'(rc[6+k]);
            end
            det_reg <= WD'(dc[0]) + WD'(dc[1]) + WD'(dc[2]);
        end
    end

    // Classify: singular flag, quotient signs and magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= (det_reg == '0);
            adet_reg <= det_reg[WD-1] ? $unsigned(-det_reg) : $unsigned(det_reg);
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k]  <= num_reg[k][WN-1] ^ det_reg[WD-1];
                anum_reg[k] <= num_reg[k][WN-1] ? $unsigned(-num_reg[k])
                                                : $unsigned(num_reg[k]);
            end
        end
    end

    assign item = {sing_reg, neg_reg, adet_reg, anum_reg[2], anum_reg[1], anum_reg[0]};

endmodule

`default_nettype wire

FILE: rtl/core/tc_queue.sv
// ----------------------------------------------------------------------------
// tc_queue: short flop-based word queue between front and back; the user must
// not push when full or pop when empty, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module tc_queue
    import tc_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output tc_qstat_t        qstat
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CNTW-1:0]  cnt_reg;

    // Store pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + AW'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + AW'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + CNTW'(1);
                2'b01:   cnt_reg <= cnt_reg - CNTW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign rdata       = mem_reg[rptr_reg];
    assign qstat.full  = (cnt_reg == CNTW'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !pop)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/core/tc_back.sv
// ----------------------------------------------------------------------------
// tc_back: rounded division and saturation
// Pops a classified word, checks each quotient against the output range,
// runs a pipelined restoring division one quotient bit per stage, then
// applies signs, clipping and the singular case into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tc_back
    import tc_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tc_qstat_t               qstat,
    output logic                    pop,
    input  logic [tc_item_w(W)-1:0] item,
    tc_out_if.source                center
);

    localparam int WD  = tc_det_w(W);
    localparam int WN  = tc_num_w(W);
    localparam int IW  = tc_item_w(W);
    localparam int WAW = WN + 1;
    localparam int WDD = WD + 1;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic            en;
    logic            o_vld_reg;

    logic            b0_vld_reg;
    logic            b0_sing_reg;
    logic [2:0]      b0_neg_reg;
    logic [WAW-1:0]  b0_a_reg [3];
    logic [WDD-1:0]  b0_d_reg;

    logic            vld_reg  [W+1];
    logic            sing_reg [W+1];
    logic [2:0]      neg_reg  [W+1];
    logic [2:0]      sat_reg  [W+1];
    logic [W-1:0]    q_reg    [W+1][3];
    logic [WAW-1:0]  rem_reg  [W][3];
    logic [WDD-1:0]  d_reg    [W];

    logic [W-1:0]    val [3];
    logic [W-1:0]    cx_reg;
    logic [W-1:0]    cy_reg;
    logic [W-1:0]    cz_reg;
    logic            sing_out_reg;
    logic            sat_out_reg;

    // Whole back advances while the output register is free or drained
    assign en  = !o_vld_reg || center.ready;
    assign pop = en && !qstat.empty;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
            for (int j = 0; j <= W; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            b0_vld_reg <= pop;
            vld_reg[0] <= b0_vld_reg;
            for (int j = 1; j <= W; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
            o_vld_reg <= vld_reg[W];
        end
    end

    // Dividend |n| + |det| and divisor 2|det| give the rounded quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_sing_reg <= item[IW-1];
            b0_neg_reg  <= item[IW-2 -: 3];
            b0_d_reg    <= {item[3*WN +: WD], 1'b0};
            for (int k = 0; k < 3; k++)
            begin
                b0_a_reg[k] <= WAW'(item[k*WN +: WN]) + WAW'(item[3*WN +: WD]);
            end
        end
    end

    // Range check: clip when the quotient reaches the bound plus one
    always_ff @(posedge clk)
    begin
        logic [WAW-1:0] lim;
        if (en)
        begin
            sing_reg[0] <= b0_sing_reg;
            neg_reg[0]  <= b0_neg_reg;
            d_reg[0]    <= b0_d_reg;
            for (int k = 0; k < 3; k++)
            begin
                lim = (WAW'(b0_d_reg) << (W - 1)) +
                      (b0_neg_reg[k] ? WAW'(b0_d_reg) : '0);
                sat_reg[0][k] <= (b0_a_reg[k] >= lim);
                rem_reg[0][k] <= b0_a_reg[k];
                q_reg[0][k]   <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage, most significant first
    for (genvar j = 1; j <= W; j++)
    begin : g_div
        localparam int B = W - j;

        logic [WAW:0] trial [3];

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                trial[k] = {1'b0, rem_reg[j-1][k]} - ((WAW+1)'(d_reg[j-1]) << B);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sing_reg[j] <= sing_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                for (int k = 0; k < 3; k++)
                begin
                    q_reg[j][k] <= q_reg[j-1][k] | (trial[k][WAW] ? '0 : (W'(1) << B));
                end
            end
        end

        if (j < W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[j] <= d_reg[j-1];
                    for (int k = 0; k < 3; k++)
                    begin
                        rem_reg[j][k] <= trial[k][WAW] ? rem_reg[j-1][k]
                                                       : trial[k][WAW-1:0];
                    end
                end
            end
        end
    end

    // Apply sign, clipping and the singular case
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (sing_reg[W])
            begin
                val[k] = '0;
            end
            else if (sat_reg[W][k])
            begin
                val[k] = neg_reg[W][k] ? MIN_NEG : MAX_POS;
            end
            else
            begin
                val[k] = neg_reg[W][k] ? -q_reg[W][k] : q_reg[W][k];
            end
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg       <= val[0];
            cy_reg       <= val[1];
            cz_reg       <= val[2];
            sing_out_reg <= sing_reg[W];
            sat_out_reg  <= !sing_reg[W] && (sat_reg[W] != 3'b000);
        end
    end

    assign center.valid     = o_vld_reg;
    assign center.center_x  = cx_reg;
    assign center.center_y  = cy_reg;
    assign center.center_z  = cz_reg;
    assign center.singular  = sing_out_reg;
    assign center.saturated = sat_out_reg;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (center.valid && center.singular) |->
        (center.center_x == '0 && center.center_y == '0 &&
         center.center_z == '0 && !center.saturated))
        else $error("singular word with nonzero center");

endmodule

`default_nettype wire

FILE: rtl/core/tetrahedron_circumcenter.sv
// ----------------------------------------------------------------------------
// tetrahedron_circumcenter: circumcenter of a tetrahedron by Cramer's rule
// Channel tet carries the four vertices a, b, c, d as signed fixed-point
// words; channel center returns the circumcenter in the same format with
// a singular flag (zero determinant, center zero) and a saturated flag
// (some coordinate clipped). Both are valid/ready; a word moves when both
// are high. Unless the front stalls, one tetrahedron is taken every
// cycle; the rate is set by the fully pipelined multipliers and the
// one-bit-per-stage divider. A word passes eight front stages (setup,
// first multipliers, cofactors, second multipliers, sums, classify), the
// queue and COORD_WIDTH + 3 back stages ending in the output register.
// When the receiver stalls, the back holds, the four-entry queue fills,
// and then the front stops taking words; results are never dropped.
// Reset clears all valid flags and the queue; no other state is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module tetrahedron_circumcenter
    import tc_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    tc_in_if.sink    tet,
    tc_out_if.source center
);

    localparam int IW = tc_item_w(COORD_WIDTH);

    tc_qstat_t      qstat;
    logic           push;
    logic           pop;
    logic [IW-1:0]  f_item;
    logic [IW-1:0]  q_item;

    // Front: setup and classify
    tc_front #(.W(COORD_WIDTH)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .tet   (tet),
        .qstat (qstat),
        .push  (push),
        .item  (f_item)
    );

    // Queue between front and back
    tc_queue #(.WIDTH(IW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (f_item),
        .pop   (pop),
        .rdata (q_item),
        .qstat (qstat)
    );

    // Back: divide, round, clip
    tc_back #(.W(COORD_WIDTH)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .pop    (pop),
        .item   (q_item),
        .center (center)
    );

endmodule

`default_nettype wire

FILE: verif/tetrahedron_circumcenter_test.sv
// ----------------------------------------------------------------------------
// tetrahedron_circumcenter_test: self-checking bench for the circumcenter
// Drives tetrahedra through the vertex channel with random idle bursts,
// stalls the center channel at random, predicts each circumcenter with
// exact wide-integer Cramer arithmetic and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tetrahedron_circumcenter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tc_pkg::*;

    localparam int W          = 32;
    localparam int NUM_RANDOM = 1650;
    localparam int CALM_ITEMS = 200;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN_CYC  = W + 20;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [W-1:0] ax, ay, az;
        logic signed [W-1:0] bx, by_coord, bz;
        logic signed [W-1:0] cx_in, cy_in, cz_in;
        logic signed [W-1:0] dx, dy, dz;
    } tetra_t;

    typedef struct packed {
        logic signed [W-1:0] center_x, center_y, center_z;
        logic                singular;
        logic                saturated;
    } center_t;

    // Predicts circumcenters and holds them until the block returns them
    class center_scoreboard;
        center_t pending_centers[$];
        int      mismatches;

        function automatic wide_t det3(input wide_t m[9]);
            return m[6] * (m[1] * m[5] - m[4] * m[2])
                 - m[7] * (m[0] * m[5] - m[2] * m[3])
                 + m[8] * (m[0] * m[4] - m[3] * m[1]);
        endfunction

        // Round to nearest, halves away from zero, then clip to the word
        function automatic logic signed [W-1:0] quotient(input wide_t num, input wide_t den,
                                                         inout logic clipped);
            logic  neg;
            wide_t un, ud, q, r, lim;
            neg = (num < 0) != (den < 0);
            un  = (num < 0) ? -num : num;
            ud  = (den < 0) ? -den : den;
            q   = un / ud;
            r   = un % ud;
            if (2 * r >= ud)
                q = q + 1;
            lim = neg ? (wide_t'(1) <<< (W - 1)) : ((wide_t'(1) <<< (W - 1)) - 1);
            if (q > lim)
            begin
                q       = lim;
                clipped = 1'b1;
            end
            if (neg)
                q = -q;
            return q[W-1:0];
        endfunction

        function automatic center_t circumcenter_of(input tetra_t t);
            wide_t   v[12];
            wide_t   m[9];
            wide_t   mk[9];
            wide_t   rhs[3];
            wide_t   det;
            center_t c;
            logic    clipped;
            v = '{t.ax, t.ay, t.az, t.bx, t.by_coord, t.bz,
                  t.cx_in, t.cy_in, t.cz_in, t.dx, t.dy, t.dz};
            for (int r = 0; r < 3; r++)
            begin
                rhs[r] = 0;
                for (int k = 0; k < 3; k++)
                begin
                    m[r*3+k] = v[9+k] - v[r*3+k];
                    rhs[r]   = rhs[r] + m[r*3+k] * (v[9+k] + v[r*3+k]);
                end
            end
            det     = det3(m);
            c       = '{default: '0};
            clipped = 1'b0;
            if (det == 0)
            begin
                c.singular = 1'b1;
                return c;
            end
            mk = m;
            for (int r = 0; r < 3; r++) mk[r*3] = rhs[r];
            c.center_x = quotient(det3(mk), 2 * det, clipped);
            mk = m;
            for (int r = 0; r < 3; r++) mk[r*3+1] = rhs[r];
            c.center_y = quotient(det3(mk), 2 * det, clipped);
            mk = m;
            for (int r = 0; r < 3; r++) mk[r*3+2] = rhs[r];
            c.center_z = quotient(det3(mk), 2 * det, clipped);
            c.saturated = clipped;
            return c;
        endfunction

        function void note_tetra(input tetra_t t);
            pending_centers.push_back(circumcenter_of(t));
        endfunction

        function void check_center(input center_t got);
            center_t exp_c;
            if (pending_centers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected center word %p", got);
                return;
            end
            exp_c = pending_centers.pop_front();
            if (got !== exp_c)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: center mismatch expected %p actual %p", exp_c, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;
    int   idle_cycles;

    tc_in_if  #(.W(W)) tet();
    tc_out_if #(.W(W)) center();

    center_scoreboard board;

    tetrahedron_circumcenter #(.COORD_WIDTH(W)) i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tet    (tet),
        .center (center)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (tet.valid && tet.ready)
            board.note_tetra('{tet.ax, tet.ay, tet.az, tet.bx, tet.by_coord, tet.bz,
                               tet.cx_in, tet.cy_in, tet.cz_in, tet.dx, tet.dy, tet.dz});
        if (center.valid && center.ready)
        begin
            center_t got;
            got = '{center.center_x, center.center_y, center.center_z,
                    center.singular, center.saturated};
            board.check_center(got);
        end
    end

    // Watchdog: end the run after a long stretch with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (tet.valid && tet.ready) || (center.valid && center.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the receiver in random bursts until the calm part
    initial
    begin
        center.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                center.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            center.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    // Present one word and hold it until accepted
    task automatic send_tetra(input tetra_t t);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            tet.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        tet.valid    <= 1'b1;
        tet.ax       <= t.ax;    tet.ay       <= t.ay;    tet.az       <= t.az;
        tet.bx       <= t.bx;    tet.by_coord <= t.by_coord; tet.bz    <= t.bz;
        tet.cx_in    <= t.cx_in; tet.cy_in    <= t.cy_in; tet.cz_in    <= t.cz_in;
        tet.dx       <= t.dx;    tet.dy       <= t.dy;    tet.dz       <= t.dz;
        do
            @(posedge clk);
        while (!(tet.valid && tet.ready));
        @(negedge clk);
    endtask

    function automatic tetra_t tetra_of(input int p[12]);
        return '{p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9], p[10], p[11]};
    endfunction

    function automatic int near(input int base, input int spread);
        return base + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Random tetrahedron: wide, local, flat, nearly flat or with shared coords
    function automatic tetra_t random_tetra();
        int p[12];
        int base[3];
        int spread;
        for (int i = 0; i < 3; i++) base[i] = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
        spread = 1 << $urandom_range(4, 24);
        for (int i = 0; i < 12; i++) p[i] = near(base[i % 3], spread);
        case ($urandom_range(0, 9))
            0, 1, 2:
                for (int i = 0; i < 12; i++) p[i] = $urandom();
            7:  // fourth vertex in the plane of the other three
                for (int k = 0; k < 3; k++) p[9+k] = p[3+k] + p[6+k] - p[k];
            8:  // fourth vertex near that plane, each coordinate off by at most one
                for (int k = 0; k < 3; k++)
                    p[9+k] = p[3+k] + p[6+k] - p[k] + (k == $urandom_range(0, 2) ? 1 : 0);
            9:  // coordinates of a copied into randomly chosen other vertices
                for (int k = 0; k < 3; k++) p[3*$urandom_range(1, 3)+k] = p[k];
            default: ;
        endcase
        return tetra_of(p);
    endfunction

    initial
    begin
        tetra_t directed[$];
        int     hi, lo, one;
        board       = new();
        calm        = 1'b0;
        rst_n       = 1'b0;
        tet.valid   = 1'b0;
        {tet.ax, tet.ay, tet.az, tet.bx, tet.by_coord, tet.bz,
         tet.cx_in, tet.cy_in, tet.cz_in, tet.dx, tet.dy, tet.dz} = '0;
        hi  = 32'sh7FFF_FFFF;
        lo  = 32'sh8000_0000;
        one = 32'sh0001_0000;

        // Directed corners, degenerate and clipping cases
        directed.push_back(tetra_of('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
        directed.push_back(tetra_of('{0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one}));
        directed.push_back(tetra_of('{one, one, one, one, -one, -one, -one, one, -one,
                                      -one, -one, one}));
        directed.push_back(tetra_of('{hi, hi, hi, lo, lo, lo, hi, lo, hi, lo, hi, lo}));
        directed.push_back(tetra_of('{lo, 0, 0, hi, 0, 0, 0, hi, 0, 0, 0, lo}));
        directed.push_back(tetra_of('{hi, 0, 0, 0, hi, 0, 0, 0, hi, lo, lo, lo}));
        directed.push_back(tetra_of('{lo, lo, lo, hi, lo, lo, lo, hi, lo, lo, lo, hi}));
        directed.push_back(tetra_of('{hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi}));
        directed.push_back(tetra_of('{0, 0, 0, one, 0, 0, 2*one, 0, 0, 0, one, 0}));
        directed.push_back(tetra_of('{0, 0, 0, hi, 0, 0, 0, hi, 0, hi, hi, 1}));
        directed.push_back(tetra_of('{0, 0, 0, lo, 0, 0, 0, lo, 0, lo, lo, -1}));
        directed.push_back(tetra_of('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1}));
        directed.push_back(tetra_of('{0, 0, 0, 2, 0, 0, 0, 2, 0, 0, 0, 2}));
        directed.push_back(tetra_of('{-1, -1, -1, 0, 0, 0, 1, 1, 1, 1, -1, 0}));
        directed.push_back(tetra_of('{one, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one}));
        directed.push_back(tetra_of('{-1, -1, -1, -1, -1, -1, 1, 2, 3, 4, 5, 6}));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i]) send_tetra(directed[i]);
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM - CALM_ITEMS)
                calm = 1'b1;
            send_tetra(random_tetra());
        end
        tet.valid <= 1'b0;

        // Drain outstanding centers, then let the pipeline settle
        while (board.pending_centers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (board.mismatches == 0 && board.pending_centers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
